// File: src/crc_framed_byte_receiver_macros.svh
// assertion macros shared by the receiver modules
`ifndef CRC_FRAMED_BYTE_RECEIVER_MACROS_SVH
`define CRC_FRAMED_BYTE_RECEIVER_MACROS_SVH

// property must hold at every edge outside reset
`define CFBR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition must never be seen outside reset
`define CFBR_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// File: src/cfbr_pkg.sv
// types, constants and the crc step for the framed byte receiver
package cfbr_pkg;

    localparam int TICK_W = 32;
    localparam int BYTE_W = 8;
    localparam int CRC_W  = 16;
    localparam int FLEN_W = 6;
    localparam int TMO_W  = 8;
    localparam int HOLD_W = 16;
    localparam int CFG_W  = 16;
    localparam int CFG_IDX_W = 1;
    localparam int DLEN_W = 8;
    localparam int BANKS  = 2;
    localparam int BANK_W = 1;
    localparam int CNT_W  = 2;

    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_ERROR = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF = 1'b1;

    localparam logic [TMO_W-1:0]  TIMEOUT_RST = 8'd4;
    localparam logic [HOLD_W-1:0] HOLDOFF_RST = 16'd200;

    typedef struct packed {
        logic [BANK_W-1:0] bank;
        logic [DLEN_W-1:0] len;
    } cfbr_desc_t;

    // msb-first bit-serial crc, data bit enters at the low end
    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] r;
        logic             top;
        r = crc;
        for (int k = 0; k < BYTE_W; k++)
        begin
            top = r[CRC_W-1];
            r   = {r[CRC_W-2:0], b[BYTE_W-1-k]};
            if (top)
            begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

endpackage

// File: src/cfbr_if.sv
// channel interfaces for events in and payload words out
interface cfbr_in_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [cfbr_pkg::BYTE_W-1:0]   data_byte;
    logic [cfbr_pkg::TICK_W-1:0]   tick;

    modport source (output valid, output op, output data_byte, output tick, input ready);
    modport sink   (input valid, input op, input data_byte, input tick, output ready);
endinterface

interface cfbr_out_if;
    logic                          valid;
    logic                          ready;
    logic [cfbr_pkg::BYTE_W-1:0]   payload_byte;
    logic [cfbr_pkg::FLEN_W-1:0]   frame_len;
    logic                          empty_frame;
    logic                          last;

    modport source (output valid, output payload_byte, output frame_len,
                    output empty_frame, output last, input ready);
    modport sink   (input valid, input payload_byte, input frame_len,
                    input empty_frame, input last, output ready);
endinterface

// File: src/cfbr_ram.sv
// generic single write port ram with registered read
module cfbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 100
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// File: src/cfbr_front.sv
// front end: event intake, framing state machine, crc check and holdoff
module cfbr_front #(
    parameter int MAX_FRAME_LEN = 50
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [cfbr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [cfbr_pkg::CFG_W-1:0]            cfg_data,
    cfbr_in_if.sink                               events,
    input  logic                                  full,
    output logic                                  push,
    output cfbr_pkg::cfbr_desc_t                  desc,
    output logic                                  ram_we,
    output logic [$clog2(cfbr_pkg::BANKS*MAX_FRAME_LEN)-1:0] ram_waddr,
    output logic [cfbr_pkg::BYTE_W-1:0]           ram_wdata
);
    import cfbr_pkg::*;

    localparam int LEN_W  = $clog2(MAX_FRAME_LEN);
    localparam int ADDR_W = $clog2(BANKS*MAX_FRAME_LEN);

    localparam logic [1:0] F_WAIT  = 2'd0;
    localparam logic [1:0] F_EVAL  = 2'd1;
    localparam logic [1:0] F_APPLY = 2'd2;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_RX   = 2'd1;
    localparam logic [1:0] PH_CRC1 = 2'd2;
    localparam logic [1:0] PH_CRC2 = 2'd3;

    logic [1:0]        fsm_reg, fsm_next;
    logic              op_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic [TICK_W-1:0] tick_reg;
    logic              gap_gt_reg, gap_ge_reg, hold_ok_reg;
    logic [CRC_W-1:0]  crc_start_reg, crc_cont_reg;

    logic [1:0]        phase_reg, phase_next;
    logic [TICK_W-1:0] last_byte_tick_reg, last_byte_tick_next;
    logic [TICK_W-1:0] last_accept_tick_reg, last_accept_tick_next;
    logic [CRC_W-1:0]  crc_reg, crc_next;
    logic [LEN_W-1:0]  widx_reg, widx_next;
    logic [LEN_W-1:0]  exp_len_reg, exp_len_next;
    logic [BANK_W-1:0] bank_reg, bank_next;
    logic [TMO_W-1:0]  timeout_reg;
    logic [HOLD_W-1:0] holdoff_reg;

    logic [TICK_W-1:0] gap, since_accept;
    logic [1:0]        eff_phase;
    logic [LEN_W:0]    widx_inc;
    logic [ADDR_W-1:0] bank_base;

    assign events.ready = (fsm_reg == F_WAIT) && !full;

    assign gap          = tick_reg - last_byte_tick_reg;
    assign since_accept = tick_reg - last_accept_tick_reg;
    assign eff_phase    = gap_gt_reg ? PH_IDLE : phase_reg;
    assign widx_inc     = {1'b0, widx_reg} + (LEN_W+1)'(1);
    assign bank_base    = (bank_reg != '0) ? ADDR_W'(MAX_FRAME_LEN) : '0;

    assign ram_waddr = bank_base + ADDR_W'(widx_reg);
    assign ram_wdata = byte_reg;
    assign desc.bank = bank_reg;
    assign desc.len  = DLEN_W'(exp_len_reg);

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RST;
            holdoff_reg <= HOLDOFF_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TIMEOUT: timeout_reg <= cfg_data[TMO_W-1:0];
                REG_HOLDOFF: holdoff_reg <= cfg_data[HOLD_W-1:0];
                default:     ;
            endcase
        end
    end

    // captured event and evaluated flags
    always_ff @(posedge clk)
    begin
        if (events.valid && events.ready)
        begin
            op_reg   <= events.op;
            byte_reg <= events.data_byte;
            tick_reg <= events.tick;
        end
        if (fsm_reg == F_EVAL)
        begin
            gap_gt_reg    <= gap > TICK_W'(timeout_reg);
            gap_ge_reg    <= gap >= TICK_W'(timeout_reg);
            hold_ok_reg   <= since_accept >= TICK_W'(holdoff_reg);
            crc_start_reg <= crc_feed('0, byte_reg);
            crc_cont_reg  <= crc_feed(crc_reg, byte_reg);
        end
    end

    always_comb
    begin
        fsm_next              = fsm_reg;
        phase_next            = phase_reg;
        last_byte_tick_next   = last_byte_tick_reg;
        last_accept_tick_next = last_accept_tick_reg;
        crc_next              = crc_reg;
        widx_next             = widx_reg;
        exp_len_next          = exp_len_reg;
        bank_next             = bank_reg;
        push                  = 1'b0;
        ram_we                = 1'b0;
        unique case (fsm_reg)
            F_WAIT:
            begin
                if (events.valid && events.ready)
                begin
                    fsm_next = F_EVAL;
                end
            end
            F_EVAL:
            begin
                fsm_next = F_APPLY;
            end
            F_APPLY:
            begin
                fsm_next = F_WAIT;
                if (op_reg == OP_ERROR)
                begin
                    phase_next = PH_IDLE;
                end
                else
                begin
                    last_byte_tick_next = tick_reg;
                    unique case (eff_phase)
                        PH_IDLE:
                        begin
                            phase_next = PH_IDLE;
                            if (gap_ge_reg && ({1'b0, byte_reg} < 9'(MAX_FRAME_LEN)))
                            begin
                                exp_len_next = LEN_W'(byte_reg);
                                crc_next     = crc_start_reg;
                                widx_next    = '0;
                                phase_next   = (byte_reg == '0) ? PH_CRC1 : PH_RX;
                            end
                        end
                        PH_RX:
                        begin
                            crc_next  = crc_cont_reg;
                            ram_we    = 1'b1;
                            widx_next = widx_inc[LEN_W-1:0];
                            if (widx_inc >= {1'b0, exp_len_reg})
                            begin
                                phase_next = PH_CRC1;
                            end
                        end
                        PH_CRC1:
                        begin
                            crc_next   = crc_cont_reg;
                            phase_next = PH_CRC2;
                        end
                        default:
                        begin
                            crc_next   = crc_cont_reg;
                            phase_next = PH_IDLE;
                            if (crc_cont_reg == '0)
                            begin
                                // holdoff restarts even when the frame is dropped
                                last_accept_tick_next = tick_reg;
                                if (hold_ok_reg)
                                begin
                                    push      = 1'b1;
                                    bank_next = bank_reg + BANK_W'(1);
                                end
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                fsm_next = F_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg              <= F_WAIT;
            phase_reg            <= PH_IDLE;
            last_byte_tick_reg   <= '0;
            last_accept_tick_reg <= '0;
            crc_reg              <= '0;
            widx_reg             <= '0;
            exp_len_reg          <= '0;
            bank_reg             <= '0;
        end
        else
        begin
            fsm_reg              <= fsm_next;
            phase_reg            <= phase_next;
            last_byte_tick_reg   <= last_byte_tick_next;
            last_accept_tick_reg <= last_accept_tick_next;
            crc_reg              <= crc_next;
            widx_reg             <= widx_next;
            exp_len_reg          <= exp_len_next;
            bank_reg             <= bank_next;
        end
    end
endmodule

// File: src/cfbr_queue.sv
// short queue of accepted frame descriptors between front and back
`include "crc_framed_byte_receiver_macros.svh"
module cfbr_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  cfbr_pkg::cfbr_desc_t        din,
    input  logic                        pop,
    output cfbr_pkg::cfbr_desc_t        dout,
    output logic                        valid,
    output logic [cfbr_pkg::CNT_W-1:0]  count
);
    import cfbr_pkg::*;

    cfbr_desc_t        slot_reg [BANKS];
    logic [BANK_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [BANK_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign dout  = slot_reg[rd_ptr_reg];
    assign valid = (count_reg != '0);
    assign count = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + BANK_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + BANK_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    `CFBR_NEVER(a_q_overflow, clk, rst_n, push && !pop && (count_reg >= CNT_W'(BANKS)), "descriptor queue overflow")
    `CFBR_NEVER(a_q_underflow, clk, rst_n, pop && (count_reg == '0), "descriptor queue underflow")
    `CFBR_ASSERT(a_q_count, clk, rst_n, push && !pop |=> count_reg == $past(count_reg) + CNT_W'(1), "queue count did not advance")
endmodule

// File: src/cfbr_back.sv
// back end: reads a stored frame and drives payload words through an output register
module cfbr_back #(
    parameter int MAX_FRAME_LEN = 50
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  q_valid,
    input  cfbr_pkg::cfbr_desc_t                  q_desc,
    output logic                                  q_pop,
    output logic                                  busy,
    output logic                                  ram_re,
    output logic [$clog2(cfbr_pkg::BANKS*MAX_FRAME_LEN)-1:0] ram_raddr,
    input  logic [cfbr_pkg::BYTE_W-1:0]           ram_rdata,
    cfbr_out_if.source                            results
);
    import cfbr_pkg::*;

    localparam int LEN_W  = $clog2(MAX_FRAME_LEN);
    localparam int ADDR_W = $clog2(BANKS*MAX_FRAME_LEN);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_READ = 2'd1;
    localparam logic [1:0] B_LOAD = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [BANK_W-1:0] bank_reg, bank_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [FLEN_W-1:0] out_len_reg;
    logic              out_empty_reg, out_last_reg;
    logic              load;
    logic              is_empty;
    logic              is_last;
    logic [LEN_W:0]    idx_inc;
    logic [ADDR_W-1:0] bank_base;

    assign is_empty  = (len_reg == '0);
    assign idx_inc   = {1'b0, idx_reg} + (LEN_W+1)'(1);
    assign is_last   = is_empty || (idx_inc == {1'b0, len_reg});
    assign bank_base = (bank_reg != '0) ? ADDR_W'(MAX_FRAME_LEN) : '0;
    assign ram_raddr = bank_base + ADDR_W'(idx_reg);
    assign busy      = (state_reg != B_IDLE);

    assign results.valid        = out_valid_reg;
    assign results.payload_byte = out_byte_reg;
    assign results.frame_len    = out_len_reg;
    assign results.empty_frame  = out_empty_reg;
    assign results.last         = out_last_reg;

    always_comb
    begin
        state_next     = state_reg;
        bank_next      = bank_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        q_pop          = 1'b0;
        ram_re         = 1'b0;
        load           = 1'b0;
        out_valid_next = out_valid_reg && !results.ready;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    bank_next  = q_desc.bank;
                    len_next   = LEN_W'(q_desc.len);
                    idx_next   = '0;
                    state_next = (q_desc.len == '0) ? B_LOAD : B_READ;
                end
            end
            B_READ:
            begin
                ram_re     = 1'b1;
                state_next = B_LOAD;
            end
            B_LOAD:
            begin
                // output register free or being drained this cycle
                if (!out_valid_reg || results.ready)
                begin
                    load           = 1'b1;
                    out_valid_next = 1'b1;
                    if (is_last)
                    begin
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_inc[LEN_W-1:0];
                        state_next = B_READ;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg  <= is_empty ? '0 : ram_rdata;
            out_len_reg   <= FLEN_W'(len_reg);
            out_empty_reg <= is_empty;
            out_last_reg  <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            bank_reg      <= '0;
            len_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bank_reg      <= bank_next;
            len_reg       <= len_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

// File: src/crc_framed_byte_receiver.sv
// top level of the crc-checked length-prefixed frame receiver
//
//  channel   | dir | word
//  ----------+-----+------------------------------------------------
//  events    | in  | op, data_byte, tick
//  results   | out | payload_byte, frame_len, empty_frame, last
//  cfg_*     | in  | register write: index, data
//
// front end per event: capture, compare and crc, state update, then a new event is taken
// back end per payload word: payload ram read, then output register load when it is free
// payload ram holds two frame banks; events stall while both hold frames not yet sent
// reset clears all control state at once; the payload ram needs no clearing
// the results register lets the back end load a word while the previous one is taken
`include "crc_framed_byte_receiver_macros.svh"
module crc_framed_byte_receiver #(
    parameter int MAX_FRAME_LEN = 50
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cfbr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cfbr_pkg::CFG_W-1:0]        cfg_data,
    cfbr_in_if.sink                           events,
    cfbr_out_if.source                        results
);
    import cfbr_pkg::*;

    localparam int ADDR_W = $clog2(BANKS*MAX_FRAME_LEN);

    cfbr_desc_t        push_desc, q_desc;
    logic              push, q_pop, q_valid, back_busy, full;
    logic [CNT_W-1:0]  q_count, owned;
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [BYTE_W-1:0] ram_wdata, ram_rdata;

    // banks held by queued frames plus the one being sent
    assign owned = q_count + CNT_W'(back_busy);
    assign full  = (owned >= CNT_W'(BANKS));

    cfbr_front #(.MAX_FRAME_LEN(MAX_FRAME_LEN)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .events    (events),
        .full      (full),
        .push      (push),
        .desc      (push_desc),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata)
    );

    cfbr_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (push_desc),
        .pop   (q_pop),
        .dout  (q_desc),
        .valid (q_valid),
        .count (q_count)
    );

    cfbr_ram #(.WIDTH(BYTE_W), .DEPTH(BANKS*MAX_FRAME_LEN)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cfbr_back #(.MAX_FRAME_LEN(MAX_FRAME_LEN)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_desc    (q_desc),
        .q_pop     (q_pop),
        .busy      (back_busy),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .results   (results)
    );

    `CFBR_NEVER(a_banks_overbooked, clk, rst_n, owned > CNT_W'(BANKS), "more frames held than payload banks")
endmodule

// File: dv/tb_crc_framed_byte_receiver.sv
// self-checking testbench for the crc-checked length-prefixed frame receiver
module tb_crc_framed_byte_receiver;
    timeunit 1ns;
    timeprecision 1ps;

    import cfbr_pkg::*;

    localparam int MAX_LEN     = 50;
    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE      = 12;
    localparam int PHASE_ITEMS = 14;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic [FLEN_W-1:0] frame_len;
        logic              empty_frame;
        logic              last;
    } word_t;

    typedef enum logic [1:0] {RX_IDLE, RX_PAYLOAD, RX_CHECK_HI, RX_CHECK_LO} rx_state_t;
    typedef enum logic [2:0] {K_LEN, K_BYTE, K_CHK_HI, K_CHK_LO, K_ERR} row_kind_t;
    typedef enum logic [2:0] {FL_NONE, FL_BAD_CHECK, FL_ERROR, FL_GAP, FL_OVERSIZE} flaw_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [BYTE_W-1:0] b;
        logic [TICK_W-1:0] tick;
        logic              typed;
        word_t             word;
    } row_t;

    localparam word_t NO_WORD    = '0;
    localparam word_t EMPTY_WORD = '{8'h00, 6'd0, 1'b1, 1'b1};
    localparam word_t FF_WORD    = '{8'hFF, 6'd1, 1'b0, 1'b1};

    // directed frames under the reset settings: timeout 4, holdoff 200
    row_t plan [27] = '{
        '{K_ERR,    8'h00, 32'd0,          1'b0, NO_WORD},
        '{K_BYTE,   8'h00, 32'd2,          1'b0, NO_WORD},     // start too early
        '{K_LEN,    8'h00, 32'd300,        1'b0, NO_WORD},
        '{K_CHK_HI, 8'h00, 32'd301,        1'b0, NO_WORD},
        '{K_CHK_LO, 8'h00, 32'd302,        1'b1, EMPTY_WORD},
        '{K_LEN,    8'h01, 32'd306,        1'b0, NO_WORD},
        '{K_BYTE,   8'hFF, 32'd310,        1'b0, NO_WORD},
        '{K_CHK_HI, 8'h00, 32'd311,        1'b0, NO_WORD},
        '{K_CHK_LO, 8'h00, 32'd312,        1'b0, NO_WORD},     // inside holdoff
        '{K_LEN,    8'h01, 32'd600,        1'b0, NO_WORD},
        '{K_BYTE,   8'hFF, 32'd601,        1'b0, NO_WORD},
        '{K_CHK_HI, 8'h00, 32'd602,        1'b0, NO_WORD},
        '{K_CHK_LO, 8'h00, 32'd603,        1'b1, FF_WORD},
        '{K_BYTE,   8'h32, 32'd900,        1'b0, NO_WORD},     // length too large
        '{K_BYTE,   8'hFF, 32'd910,        1'b0, NO_WORD},
        '{K_LEN,    8'h02, 32'd920,        1'b0, NO_WORD},
        '{K_BYTE,   8'h00, 32'd921,        1'b0, NO_WORD},
        '{K_ERR,    8'hFF, 32'd922,        1'b0, NO_WORD},     // error aborts the frame
        '{K_LEN,    8'h01, 32'd1000,       1'b0, NO_WORD},
        '{K_BYTE,   8'hA5, 32'd1010,       1'b0, NO_WORD},     // gap too long
        '{K_LEN,    8'h01, 32'd2000,       1'b0, NO_WORD},
        '{K_BYTE,   8'h3C, 32'd2001,       1'b0, NO_WORD},
        '{K_BYTE,   8'h00, 32'd2002,       1'b0, NO_WORD},     // wrong check bytes
        '{K_BYTE,   8'h00, 32'd2003,       1'b0, NO_WORD},
        '{K_LEN,    8'h00, 32'hFFFF_FFFF,  1'b0, NO_WORD},
        '{K_CHK_HI, 8'h00, 32'd0,          1'b0, NO_WORD},     // tick wraps
        '{K_CHK_LO, 8'h00, 32'd1,          1'b1, EMPTY_WORD}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    cfbr_in_if  event_ch ();
    cfbr_out_if word_ch ();

    crc_framed_byte_receiver #(
        .MAX_FRAME_LEN (MAX_LEN)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .events    (event_ch),
        .results   (word_ch)
    );

    // predictor state and its copy of the registers
    logic [TMO_W-1:0]  timeout_cfg;
    logic [HOLD_W-1:0] holdoff_cfg;
    rx_state_t         rx_state;
    logic [TICK_W-1:0] prev_byte_tick;
    logic [TICK_W-1:0] prev_good_tick;
    logic [CRC_W-1:0]  rx_crc;
    logic [BYTE_W-1:0] rx_buf [MAX_LEN];
    logic [FLEN_W-1:0] rx_count;
    logic [FLEN_W-1:0] rx_len;

    word_t expected_words [$];
    word_t got_word;
    word_t want_word;
    int    mismatches;
    int    new_words;
    int    cycle_count;

    // stimulus side
    logic              typed_on;
    word_t             typed_word;
    logic [TICK_W-1:0] now;
    logic [CRC_W-1:0]  tx_crc;
    logic [CRC_W-1:0]  tx_check;
    int                frame_items;
    int                send_idle_pct;
    int                stall_pct;
    int                stall_hold;

    function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] acc;
        logic             carry;
        acc = crc;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            carry = acc[CRC_W-1];
            acc   = {acc[CRC_W-2:0], b[i]} ^ (carry ? CRC_POLY : '0);
        end
        return acc;
    endfunction

    // advances the predictor by one event, queues its words, returns how many
    function automatic int predict_event(input logic op, input logic [BYTE_W-1:0] b,
                                         input logic [TICK_W-1:0] tick);
        logic [TICK_W-1:0] gap;
        int                n;
        n = 0;
        if (op == OP_ERROR)
        begin
            rx_state = RX_IDLE;
            return 0;
        end
        gap = tick - prev_byte_tick;
        if (gap > TICK_W'(timeout_cfg))
        begin
            rx_state = RX_IDLE;
        end
        case (rx_state)
            RX_IDLE:
            begin
                if (gap >= TICK_W'(timeout_cfg) && b < MAX_LEN)
                begin
                    rx_len   = FLEN_W'(b);
                    rx_crc   = crc_step('0, b);
                    rx_count = '0;
                    rx_state = (b == 8'h00) ? RX_CHECK_HI : RX_PAYLOAD;
                end
            end
            RX_PAYLOAD:
            begin
                rx_crc           = crc_step(rx_crc, b);
                rx_buf[rx_count] = b;
                rx_count         = rx_count + 1'b1;
                if (rx_count >= rx_len)
                begin
                    rx_state = RX_CHECK_HI;
                end
            end
            RX_CHECK_HI:
            begin
                rx_crc   = crc_step(rx_crc, b);
                rx_state = RX_CHECK_LO;
            end
            default:
            begin
                rx_crc = crc_step(rx_crc, b);
                if (rx_crc == '0)
                begin
                    if (tick - prev_good_tick >= TICK_W'(holdoff_cfg))
                    begin
                        if (rx_len == '0)
                        begin
                            expected_words.push_back(EMPTY_WORD);
                            n = 1;
                        end
                        else
                        begin
                            for (int i = 0; i < rx_len; i++)
                            begin
                                expected_words.push_back('{rx_buf[i], rx_len, 1'b0,
                                                           (i == rx_len - 1)});
                            end
                            n = rx_len;
                        end
                    end
                    prev_good_tick = tick;
                end
                rx_state = RX_IDLE;
            end
        endcase
        prev_byte_tick = tick;
        return n;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver side: long hold-off first, random stalls otherwise
    always @(negedge clk)
    begin
        if (stall_hold > 0)
        begin
            word_ch.ready <= 1'b0;
            stall_hold = stall_hold - 1;
        end
        else
        begin
            word_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && word_ch.valid && word_ch.ready)
        begin
            got_word = '{word_ch.payload_byte, word_ch.frame_len,
                         word_ch.empty_frame, word_ch.last};
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected word: byte %02h len %0d empty %0b last %0b",
                             got_word.payload_byte, got_word.frame_len,
                             got_word.empty_frame, got_word.last);
                end
            end
            else
            begin
                want_word = expected_words.pop_front();
                if (got_word !== want_word)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("word mismatch: expected byte %02h len %0d empty %0b last %0b,",
                                 want_word.payload_byte, want_word.frame_len,
                                 want_word.empty_frame, want_word.last);
                        $display("               got byte %02h len %0d empty %0b last %0b",
                                 got_word.payload_byte, got_word.frame_len,
                                 got_word.empty_frame, got_word.last);
                    end
                end
            end
        end
        if (rst_n && event_ch.valid && event_ch.ready)
        begin
            new_words = predict_event(event_ch.op, event_ch.data_byte, event_ch.tick);
            if (typed_on)
            begin
                repeat (new_words) void'(expected_words.pop_back());
                expected_words.push_back(typed_word);
            end
        end
    end

    // starts and ends at a falling edge
    task automatic push_event(input logic op, input logic [BYTE_W-1:0] b,
                              input logic [TICK_W-1:0] tick);
        while ($urandom_range(99) < send_idle_pct)
        begin
            event_ch.valid <= 1'b0;
            @(negedge clk);
        end
        event_ch.valid     <= 1'b1;
        event_ch.op        <= op;
        event_ch.data_byte <= b;
        event_ch.tick      <= tick;
        @(posedge clk);
        while (!event_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b, input int unsigned gap);
        now = now + TICK_W'(gap);
        push_event(OP_DATA, b, now);
    endtask

    task automatic send_frame(input int unsigned len, input flaw_t flaw);
        logic [CRC_W-1:0]  crc;
        logic [CRC_W-1:0]  check;
        logic [BYTE_W-1:0] b;
        int unsigned       cut;
        int unsigned       gap;
        // half the frames come late enough to clear the holdoff
        if ($urandom_range(1) == 1)
        begin
            now = now + TICK_W'(holdoff_cfg);
        end
        gap = timeout_cfg + $urandom_range(0, 3);
        b   = (flaw == FL_OVERSIZE) ? BYTE_W'($urandom_range(MAX_LEN, 255)) : BYTE_W'(len);
        send_byte(b, gap);
        frame_items++;
        if (flaw == FL_OVERSIZE)
        begin
            return;
        end
        crc   = crc_step('0, b);
        check = '0;
        cut   = $urandom_range(0, len + 1);
        for (int unsigned pos = 0; pos < len + 2; pos++)
        begin
            gap = $urandom_range(0, timeout_cfg);
            if (pos == len)
            begin
                check = crc_step(crc_step(crc, 8'h00), 8'h00);
                if (flaw == FL_BAD_CHECK)
                begin
                    check = check ^ CRC_W'($urandom_range(1, 65535));
                end
            end
            if (pos == cut && flaw == FL_ERROR)
            begin
                now = now + TICK_W'(gap);
                push_event(OP_ERROR, BYTE_W'($urandom_range(255)), now);
                frame_items++;
                return;
            end
            if (pos == cut && flaw == FL_GAP)
            begin
                gap = timeout_cfg + 1 + $urandom_range(0, 20);
            end
            if (pos < len)
            begin
                b   = BYTE_W'($urandom_range(255));
                crc = crc_step(crc, b);
            end
            else
            begin
                b = (pos == len) ? check[15:8] : check[7:0];
            end
            send_byte(b, gap);
            frame_items++;
        end
    endtask

    // idle phases only: timeout and holdoff
    task automatic program_regs(input logic [TMO_W-1:0] tmo, input logic [HOLD_W-1:0] hold);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_TIMEOUT;
        cfg_data  <= {8'($urandom_range(255)), tmo};   // upper bits unused
        @(negedge clk);
        cfg_index <= REG_HOLDOFF;
        cfg_data  <= hold;
        @(negedge clk);
        cfg_we    <= 1'b0;
        timeout_cfg = tmo;
        holdoff_cfg = hold;
    endtask

    // called at a falling edge, returns at a rising edge
    task automatic wait_drained();
        event_ch.valid <= 1'b0;
        while (expected_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        logic [TMO_W-1:0]  tmo;
        logic [HOLD_W-1:0] hold;
        int                r;
        int unsigned       len;
        row_t              row;

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = REG_TIMEOUT;
        cfg_data           = '0;
        event_ch.valid     = 1'b0;
        event_ch.op        = OP_DATA;
        event_ch.data_byte = '0;
        event_ch.tick      = '0;
        word_ch.ready      = 1'b0;
        typed_on           = 1'b0;
        typed_word         = NO_WORD;
        send_idle_pct      = 0;
        stall_pct          = 0;
        stall_hold         = 0;
        mismatches         = 0;
        cycle_count        = 0;
        timeout_cfg        = TIMEOUT_RST;
        holdoff_cfg        = HOLDOFF_RST;
        rx_state           = RX_IDLE;
        prev_byte_tick     = '0;
        prev_good_tick     = '0;
        rx_crc             = '0;
        rx_count           = '0;
        rx_len             = '0;
        tx_crc             = '0;
        tx_check           = '0;
        now                = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i])
        begin
            row        = plan[i];
            typed_on   = row.typed;
            typed_word = row.word;
            case (row.kind)
                K_LEN:
                begin
                    tx_crc = crc_step('0, row.b);
                    push_event(OP_DATA, row.b, row.tick);
                end
                K_BYTE:
                begin
                    tx_crc = crc_step(tx_crc, row.b);
                    push_event(OP_DATA, row.b, row.tick);
                end
                K_CHK_HI:
                begin
                    tx_check = crc_step(crc_step(tx_crc, 8'h00), 8'h00);
                    push_event(OP_DATA, tx_check[15:8], row.tick);
                end
                K_CHK_LO:
                begin
                    push_event(OP_DATA, tx_check[7:0], row.tick);
                end
                default:
                begin
                    push_event(OP_ERROR, row.b, row.tick);
                end
            endcase
        end
        typed_on = 1'b0;

        for (int p = 0; p < 4; p++)
        begin
            wait_drained();
            case (p)
                0:
                begin
                    tmo = 8'd0;   hold = 16'd0;     send_idle_pct = 0;  stall_pct = 0;
                    stall_hold = 600;
                end
                1:
                begin
                    tmo = 8'd255; hold = 16'hFFFF;  send_idle_pct = 45; stall_pct = 0;
                end
                2:
                begin
                    tmo  = 8'($urandom_range(1, 30));
                    hold = 16'($urandom_range(0, 500));
                    send_idle_pct = 0;  stall_pct = 45;
                end
                default:
                begin
                    tmo = 8'd7;   hold = 16'd50;    send_idle_pct = 9;  stall_pct = 9;
                end
            endcase
            program_regs(tmo, hold);
            now         = $urandom();
            frame_items = 0;
            if (p == 0)
            begin
                // longest frame, then two more while the receiver holds off
                send_frame(MAX_LEN - 1, FL_NONE);
                send_frame(1, FL_NONE);
                send_frame(1, FL_NONE);
            end
            while (frame_items < PHASE_ITEMS)
            begin
                r   = $urandom_range(99);
                len = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
                if (r < 65)
                    send_frame(len, FL_NONE);
                else if (r < 75)
                    send_frame(len, FL_BAD_CHECK);
                else if (r < 82)
                    send_frame(len, FL_ERROR);
                else if (r < 88)
                    send_frame(len, FL_GAP);
                else if (r < 92)
                    send_frame(len, FL_OVERSIZE);
                else if ($urandom_range(1) == 1)
                begin
                    now = now + TICK_W'($urandom_range(0, 3));
                    push_event(OP_ERROR, BYTE_W'($urandom_range(255)), now);
                end
                else
                    send_byte(BYTE_W'($urandom_range(255)), $urandom_range(0, timeout_cfg + 2));
            end
        end

        wait_drained();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
